// ===== rtl/core/half_duplex_radio_state_controller_top_defines.svh =====
// assertion macros shared by the radio controller rtl
`ifndef HALF_DUPLEX_RADIO_STATE_CONTROLLER_TOP_DEFINES_SVH
`define HALF_DUPLEX_RADIO_STATE_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, clocked on aclk, off while aresetn is low
`define HDRSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while aresetn is low
`define HDRSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hdrsc_pkg.sv =====
// types and constants shared by the radio controller modules
package hdrsc_pkg;

    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 72;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int NOW_W = 48;
    localparam int PID_W = 16;
    localparam int LEVEL_W = 11;
    localparam int CHAN_W = 8;
    localparam int SYM_W = 32;
    localparam int MOD_W = 8;
    localparam int SIDX_W = 3;
    localparam int STATE_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULATION = 2'd3;

    localparam logic signed [LEVEL_W-1:0] SENSITIVITY_RST = -11'sd360;
    localparam logic [SYM_W-1:0] SYMBOL_TIME_RST = 32'd4000;
    localparam logic signed [LEVEL_W-1:0] LEVEL_NONE = -11'sd1024;

    // request codes
    localparam logic [3:0] REQ_TX_START = 4'd0;
    localparam logic [3:0] REQ_TX_END = 4'd1;
    localparam logic [3:0] REQ_RX_END = 4'd2;
    localparam logic [3:0] REQ_CS = 4'd3;
    localparam logic [3:0] REQ_SLEEP = 4'd4;
    localparam logic [3:0] REQ_WAKE = 4'd5;
    localparam logic [3:0] REQ_LISTEN = 4'd6;
    localparam logic [3:0] REQ_IDLE = 4'd7;
    localparam logic [3:0] REQ_CS_RESET = 4'd8;
    localparam logic [3:0] REQ_READ = 4'd9;

    // radio state codes as seen on the result
    localparam logic [STATE_W-1:0] ST_SLEEP = 3'd0;
    localparam logic [STATE_W-1:0] ST_IDLE = 3'd1;
    localparam logic [STATE_W-1:0] ST_LISTEN = 3'd2;
    localparam logic [STATE_W-1:0] ST_RXING = 3'd3;
    localparam logic [STATE_W-1:0] ST_TX = 3'd4;
    localparam logic [STATE_W-1:0] NUM_STATES = 3'd5;

    typedef enum logic [3:0] {
        OP_TX_START,
        OP_TX_END,
        OP_RX_END,
        OP_CS,
        OP_SLEEP,
        OP_WAKE,
        OP_LISTEN,
        OP_IDLE,
        OP_CS_RESET,
        OP_READ,
        OP_NONE
    } op_t;

    // one classified request as it waits in the queue
    typedef struct packed {
        op_t                        op;
        logic [NOW_W-1:0]           now_ns;
        logic [PID_W-1:0]           packet_id;
        logic signed [LEVEL_W-1:0]  rx_level;
        logic                       cs_match;
        logic                       per_drop;
        logic                       node_alive;
        logic                       read_ok;
        logic [SIDX_W-1:0]          read_idx;
    } cmd_t;

endpackage

// ===== rtl/core/half_duplex_radio_state_controller_top.sv =====
// top level of the half-duplex radio mode controller
//
//  port group | dir | width           | carries
//  s_*        | in  | 128 + 4 tuser   | one radio event request
//  m_*        | out | 72              | mode, flags, lock level, duration
//  cfg_*      | in  | 2 idx + 32 data | sensitivity, channel, symbol time, modulation
//
// sustains one request per cycle when the output is not stalled; a taken request
// is registered in a queue slot and then in the result register
// the back end updates mode, owners and one time counter in the same cycle
// (one time subtract feeding one counter add)
// aresetn clears mode, owners, lock and all five counters at once, no sweep
// a two-entry queue and the result register let either side stall alone

`include "half_duplex_radio_state_controller_top_defines.svh"

module half_duplex_radio_state_controller_top #(
    parameter int TIME_BITS = 48,
    parameter int ID_BITS   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [hdrsc_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [hdrsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ns[47:0], packet_id, rx_level, pkt_channel, pkt_symbol_time,
    // pkt_modulation, per_drop, node_alive, state_index[127:125]
    input  logic [hdrsc_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic [hdrsc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // radio_state[2:0], transmit_start, forward_packet, dropped, cs_level,
    // duration_value[64:17], zero fill
    output logic [hdrsc_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic            q_full;
    logic            q_push;
    hdrsc_pkg::cmd_t push_cmd;
    logic            q_valid;
    hdrsc_pkg::cmd_t q_cmd;
    logic            q_pop;

    hdrsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    hdrsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (q_pop)
    );

    hdrsc_back #(
        .TIME_BITS (TIME_BITS),
        .ID_BITS   (ID_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `HDRSC_ASSERT_NOW(a_one_flag, m_tvalid, $countones(m_tdata[5:3]) <= 1, "more than one event flag")
    `HDRSC_ASSERT_NOW(a_txs_mode, m_tvalid && m_tdata[3], m_tdata[2:0] == hdrsc_pkg::ST_TX, "transmit start outside transmit mode")
    `HDRSC_ASSERT_NOW(a_fwd_mode, m_tvalid && m_tdata[4], m_tdata[2:0] == hdrsc_pkg::ST_IDLE, "forwarded packet outside idle mode")
    `HDRSC_ASSERT_NEXT(a_drain, q_valid && (!m_tvalid || m_tready), m_tvalid, "queued request not moved to output")

endmodule

// ===== rtl/core/hdrsc_front.sv =====
// front end: config registers, request decode and packet filter match
module hdrsc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [hdrsc_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [hdrsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hdrsc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [hdrsc_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                              q_full,
    output logic                              q_push,
    output hdrsc_pkg::cmd_t                   q_cmd
);

    logic signed [hdrsc_pkg::LEVEL_W-1:0] sens_reg;
    logic [hdrsc_pkg::CHAN_W-1:0]         chan_reg;
    logic [hdrsc_pkg::SYM_W-1:0]          sym_reg;
    logic [hdrsc_pkg::MOD_W-1:0]          mod_reg;

    logic signed [hdrsc_pkg::LEVEL_W-1:0] level;
    logic [hdrsc_pkg::CHAN_W-1:0]         pkt_chan;
    logic [hdrsc_pkg::SYM_W-1:0]          pkt_sym;
    logic [hdrsc_pkg::MOD_W-1:0]          pkt_mod;
    logic [hdrsc_pkg::SIDX_W-1:0]         sidx;
    hdrsc_pkg::op_t                       op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg <= hdrsc_pkg::SENSITIVITY_RST;
            chan_reg <= '0;
            sym_reg  <= hdrsc_pkg::SYMBOL_TIME_RST;
            mod_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                hdrsc_pkg::CFG_SENSITIVITY: sens_reg <= $signed(cfg_wdata[10:0]);
                hdrsc_pkg::CFG_CHANNEL:     chan_reg <= cfg_wdata[7:0];
                hdrsc_pkg::CFG_SYMBOL_TIME: sym_reg  <= cfg_wdata[31:0];
                hdrsc_pkg::CFG_MODULATION:  mod_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (s_tuser)
            hdrsc_pkg::REQ_TX_START: op = hdrsc_pkg::OP_TX_START;
            hdrsc_pkg::REQ_TX_END:   op = hdrsc_pkg::OP_TX_END;
            hdrsc_pkg::REQ_RX_END:   op = hdrsc_pkg::OP_RX_END;
            hdrsc_pkg::REQ_CS:       op = hdrsc_pkg::OP_CS;
            hdrsc_pkg::REQ_SLEEP:    op = hdrsc_pkg::OP_SLEEP;
            hdrsc_pkg::REQ_WAKE:     op = hdrsc_pkg::OP_WAKE;
            hdrsc_pkg::REQ_LISTEN:   op = hdrsc_pkg::OP_LISTEN;
            hdrsc_pkg::REQ_IDLE:     op = hdrsc_pkg::OP_IDLE;
            hdrsc_pkg::REQ_CS_RESET: op = hdrsc_pkg::OP_CS_RESET;
            hdrsc_pkg::REQ_READ:     op = hdrsc_pkg::OP_READ;
            default:                 op = hdrsc_pkg::OP_NONE;
        endcase
    end

    assign level    = $signed(s_tdata[74:64]);
    assign pkt_chan = s_tdata[82:75];
    assign pkt_sym  = s_tdata[114:83];
    assign pkt_mod  = s_tdata[122:115];
    assign sidx     = s_tdata[127:125];

    always_comb begin
        q_cmd.op         = op;
        q_cmd.now_ns     = s_tdata[47:0];
        q_cmd.packet_id  = s_tdata[63:48];
        q_cmd.rx_level   = level;
        // everything but the capture compare, which needs the live lock level
        q_cmd.cs_match   = (level >= sens_reg) && (pkt_chan == chan_reg)
                           && (pkt_sym == sym_reg) && (pkt_mod == mod_reg);
        q_cmd.per_drop   = s_tdata[123];
        q_cmd.node_alive = s_tdata[124];
        q_cmd.read_ok    = sidx < hdrsc_pkg::NUM_STATES;
        q_cmd.read_idx   = sidx;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// ===== rtl/core/hdrsc_queue.sv =====
// two-entry queue of classified requests between front and back
module hdrsc_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  hdrsc_pkg::cmd_t  push_cmd,
    output logic             full,
    output logic             q_valid,
    output hdrsc_pkg::cmd_t  q_cmd,
    input  logic             pop
);

    hdrsc_pkg::cmd_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= push_cmd;
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign full    = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_cmd   = slot_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/hdrsc_back.sv =====
// back end: radio mode machine, owners, capture lock, time counters, result register
module hdrsc_back #(
    parameter int TIME_BITS = 48,
    parameter int ID_BITS   = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  hdrsc_pkg::cmd_t                  q_cmd,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hdrsc_pkg::M_TDATA_W-1:0]  m_tdata
);

    typedef enum logic [hdrsc_pkg::STATE_W-1:0] {
        MODE_SLEEP  = hdrsc_pkg::ST_SLEEP,
        MODE_IDLE   = hdrsc_pkg::ST_IDLE,
        MODE_LISTEN = hdrsc_pkg::ST_LISTEN,
        MODE_RXING  = hdrsc_pkg::ST_RXING,
        MODE_TX     = hdrsc_pkg::ST_TX
    } mode_t;

    mode_t                                mode_reg, mode_next;
    logic [TIME_BITS-1:0]                 since_reg;
    logic                                 tx_valid_reg, tx_valid_next;
    logic [ID_BITS-1:0]                   tx_id_reg, tx_id_next;
    logic                                 rx_valid_reg, rx_valid_next;
    logic [ID_BITS-1:0]                   rx_id_reg, rx_id_next;
    logic signed [hdrsc_pkg::LEVEL_W-1:0] lock_reg, lock_next;
    logic                                 spoil_reg, spoil_next;
    logic [TIME_BITS-1:0]                 dur_reg [hdrsc_pkg::NUM_STATES];

    logic                                 out_valid_reg;
    mode_t                                out_mode_reg;
    logic                                 out_txs_reg, out_txs_next;
    logic                                 out_fwd_reg, out_fwd_next;
    logic                                 out_drop_reg, out_drop_next;
    logic [hdrsc_pkg::NOW_W-1:0]          out_dur_reg, out_dur_next;

    logic [TIME_BITS-1:0]                 now_t;
    logic [ID_BITS-1:0]                   id_t;
    logic [TIME_BITS-1:0]                 elapsed;
    logic [TIME_BITS-1:0]                 addend;
    logic [TIME_BITS-1:0]                 acc;
    logic [hdrsc_pkg::SIDX_W-1:0]         sel_idx;
    logic                                 is_read;
    logic                                 changed;
    logic                                 spoil_set;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_comb begin
        now_t   = TIME_BITS'(q_cmd.now_ns);
        id_t    = ID_BITS'(q_cmd.packet_id);
        elapsed = now_t - since_reg;
        is_read = q_cmd.op == hdrsc_pkg::OP_READ;
        // one counter port: the read target, else the mode being left
        sel_idx = (is_read && q_cmd.read_ok) ? q_cmd.read_idx : mode_reg;
        addend  = (is_read && (q_cmd.read_idx != mode_reg)) ? '0 : elapsed;
        acc     = dur_reg[sel_idx] + addend;

        mode_next     = mode_reg;
        tx_valid_next = tx_valid_reg;
        tx_id_next    = tx_id_reg;
        rx_valid_next = rx_valid_reg;
        rx_id_next    = rx_id_reg;
        lock_next     = lock_reg;
        spoil_next    = spoil_reg;
        changed       = 1'b0;
        spoil_set     = 1'b0;
        out_txs_next  = 1'b0;
        out_fwd_next  = 1'b0;
        out_drop_next = 1'b0;
        out_dur_next  = '0;

        unique case (q_cmd.op)
            hdrsc_pkg::OP_TX_START: begin
                if (mode_reg == MODE_SLEEP) begin
                    out_drop_next = 1'b1;
                end else begin
                    rx_valid_next = 1'b0;
                    lock_next     = hdrsc_pkg::LEVEL_NONE;
                    tx_valid_next = 1'b1;
                    tx_id_next    = id_t;
                    mode_next     = MODE_TX;
                    changed       = 1'b1;
                    out_txs_next  = 1'b1;
                end
            end
            hdrsc_pkg::OP_TX_END: begin
                if (q_cmd.node_alive && tx_valid_reg && (tx_id_reg == id_t)) begin
                    tx_valid_next = 1'b0;
                    mode_next     = MODE_IDLE;
                    changed       = mode_reg != MODE_IDLE;
                    spoil_set     = rx_valid_reg && (mode_reg != MODE_IDLE);
                end
            end
            hdrsc_pkg::OP_RX_END: begin
                if (tx_valid_reg || (mode_reg != MODE_RXING) || !rx_valid_reg
                        || (rx_id_reg != id_t)) begin
                    out_drop_next = 1'b1;
                end else begin
                    rx_valid_next = 1'b0;
                    lock_next     = hdrsc_pkg::LEVEL_NONE;
                    changed       = 1'b1;
                    mode_next     = MODE_LISTEN;
                    if (!q_cmd.node_alive || q_cmd.per_drop) begin
                        out_drop_next = 1'b1;
                    end else begin
                        spoil_next = 1'b0;
                        if (!spoil_reg) begin
                            mode_next    = MODE_IDLE;
                            out_fwd_next = 1'b1;
                        end else begin
                            out_drop_next = 1'b1;
                        end
                    end
                end
            end
            hdrsc_pkg::OP_CS: begin
                if (!tx_valid_reg && ((mode_reg == MODE_LISTEN) || (mode_reg == MODE_RXING))
                        && q_cmd.cs_match && (q_cmd.rx_level > lock_reg)) begin
                    lock_next     = q_cmd.rx_level;
                    mode_next     = MODE_RXING;
                    changed       = mode_reg != MODE_RXING;
                    spoil_set     = rx_valid_reg && (mode_reg != MODE_RXING);
                    rx_valid_next = 1'b1;
                    rx_id_next    = id_t;
                end
            end
            hdrsc_pkg::OP_SLEEP: begin
                // changed is set unconditionally, so the interval always closes
                tx_valid_next = 1'b0;
                rx_valid_next = 1'b0;
                lock_next     = hdrsc_pkg::LEVEL_NONE;
                mode_next     = MODE_SLEEP;
                changed       = 1'b1;
            end
            hdrsc_pkg::OP_WAKE, hdrsc_pkg::OP_CS_RESET: begin
                tx_valid_next = 1'b0;
                rx_valid_next = 1'b0;
                lock_next     = hdrsc_pkg::LEVEL_NONE;
                mode_next     = MODE_IDLE;
                changed       = mode_reg != MODE_IDLE;
            end
            hdrsc_pkg::OP_LISTEN: begin
                mode_next = MODE_LISTEN;
                changed   = mode_reg != MODE_LISTEN;
                spoil_set = rx_valid_reg && (mode_reg != MODE_LISTEN);
            end
            hdrsc_pkg::OP_IDLE: begin
                mode_next = MODE_IDLE;
                changed   = mode_reg != MODE_IDLE;
                spoil_set = rx_valid_reg && (mode_reg != MODE_IDLE);
            end
            hdrsc_pkg::OP_READ: begin
                if (q_cmd.read_ok) begin
                    out_dur_next = hdrsc_pkg::NOW_W'(acc);
                end
            end
            default: ;
        endcase

        if (spoil_set) begin
            spoil_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_SLEEP;
            since_reg     <= '0;
            tx_valid_reg  <= 1'b0;
            rx_valid_reg  <= 1'b0;
            lock_reg      <= hdrsc_pkg::LEVEL_NONE;
            spoil_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < int'(hdrsc_pkg::NUM_STATES); i++) begin
                dur_reg[i] <= '0;
            end
        end else begin
            if (q_pop) begin
                mode_reg      <= mode_next;
                tx_valid_reg  <= tx_valid_next;
                tx_id_reg     <= tx_id_next;
                rx_valid_reg  <= rx_valid_next;
                rx_id_reg     <= rx_id_next;
                lock_reg      <= lock_next;
                spoil_reg     <= spoil_next;
                if (changed) begin
                    dur_reg[sel_idx] <= acc;
                    since_reg        <= now_t;
                end
                out_valid_reg <= 1'b1;
                out_mode_reg  <= mode_next;
                out_txs_reg   <= out_txs_next;
                out_fwd_reg   <= out_fwd_next;
                out_drop_reg  <= out_drop_next;
                out_dur_reg   <= out_dur_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    // cs_level follows the lock as it stands after the request
    assign m_tdata  = {7'd0, out_dur_reg, lock_reg, out_drop_reg, out_fwd_reg,
                       out_txs_reg, out_mode_reg};

endmodule

// ===== test/tb_half_duplex_radio_state_controller_top.sv =====
// self-checking testbench for the half-duplex radio mode controller top level
module tb_half_duplex_radio_state_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    // request code with no meaning to the block
    localparam logic [3:0] REQ_UNUSED_TOP = 4'd15;
    localparam int SCRIPT_LEN = 28;
    localparam int PHASE_EVENTS = 385;

    typedef struct packed {
        logic [3:0]                    req;
        logic [hdrsc_pkg::NOW_W-1:0]   now;
        logic [hdrsc_pkg::PID_W-1:0]   pid;
        logic [hdrsc_pkg::LEVEL_W-1:0] level;
        logic [hdrsc_pkg::CHAN_W-1:0]  chan;
        logic [hdrsc_pkg::SYM_W-1:0]   psym;
        logic [hdrsc_pkg::MOD_W-1:0]   pmod;
        logic                          per;
        logic                          alive;
        logic [hdrsc_pkg::SIDX_W-1:0]  sidx;
    } radio_event_t;

    typedef struct packed {
        logic [hdrsc_pkg::STATE_W-1:0] state;
        logic                          txs;
        logic                          fwd;
        logic                          drop;
        logic [hdrsc_pkg::LEVEL_W-1:0] lvl;
        logic [hdrsc_pkg::NOW_W-1:0]   dur;
    } radio_report_t;

    typedef struct packed {
        radio_event_t  ev;
        logic          fixed;
        radio_report_t rep;
    } script_row_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_we;
    logic [hdrsc_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [hdrsc_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [hdrsc_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [hdrsc_pkg::S_TUSER_W-1:0]  s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [hdrsc_pkg::M_TDATA_W-1:0]  m_tdata;

    // mirror of the radio state
    logic [hdrsc_pkg::STATE_W-1:0]        md;
    logic [hdrsc_pkg::NOW_W-1:0]          since;
    bit                                   txv;
    bit                                   rxv;
    logic [hdrsc_pkg::PID_W-1:0]          txid;
    logic [hdrsc_pkg::PID_W-1:0]          rxid;
    logic signed [hdrsc_pkg::LEVEL_W-1:0] lock;
    bit                                   spoil;
    logic [hdrsc_pkg::NOW_W-1:0]          acc [5];

    logic signed [hdrsc_pkg::LEVEL_W-1:0] cfg_sens;
    logic [hdrsc_pkg::CHAN_W-1:0]         cfg_chan;
    logic [hdrsc_pkg::SYM_W-1:0]          cfg_sym;
    logic [hdrsc_pkg::MOD_W-1:0]          cfg_mod;

    radio_report_t report_q [$];
    logic [hdrsc_pkg::NOW_W-1:0] clock_ns;
    bit steady;
    int accepted_events;
    int mismatches;
    int stall_left;

    script_row_t script [SCRIPT_LEN] = '{
        '{'{hdrsc_pkg::REQ_READ, 48'd100, 16'h0000, hdrsc_pkg::LEVEL_NONE, 8'h00, 32'd0,
            8'h00, 1'b0, 1'b0, 3'd0},
          1'b1, '{hdrsc_pkg::ST_SLEEP, 1'b0, 1'b0, 1'b0, hdrsc_pkg::LEVEL_NONE, 48'd100}},
        '{'{hdrsc_pkg::REQ_TX_START, 48'd200, 16'hFFFF, 11'h3FF, 8'hFF, 32'hFFFF_FFFF,
            8'hFF, 1'b1, 1'b1, 3'd7},
          1'b1, '{hdrsc_pkg::ST_SLEEP, 1'b0, 1'b0, 1'b1, hdrsc_pkg::LEVEL_NONE, 48'd0}},
        '{'{hdrsc_pkg::REQ_RX_END, 48'd300, 16'h0000, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0},
          1'b1, '{hdrsc_pkg::ST_SLEEP, 1'b0, 1'b0, 1'b1, hdrsc_pkg::LEVEL_NONE, 48'd0}},
        '{'{hdrsc_pkg::REQ_CS, 48'd400, 16'h0001, 11'd100, 8'h00, 32'd4000, 8'h00, 1'b0,
            1'b1, 3'd0},
          1'b1, '{hdrsc_pkg::ST_SLEEP, 1'b0, 1'b0, 1'b0, hdrsc_pkg::LEVEL_NONE, 48'd0}},
        '{'{hdrsc_pkg::REQ_WAKE, 48'd1000, 16'h0000, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0},
          1'b1, '{hdrsc_pkg::ST_IDLE, 1'b0, 1'b0, 1'b0, hdrsc_pkg::LEVEL_NONE, 48'd0}},
        '{'{hdrsc_pkg::REQ_LISTEN, 48'd2000, 16'h0000, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        // one step below sensitivity, then exactly at it
        '{'{hdrsc_pkg::REQ_CS, 48'd2100, 16'h1111, -11'sd361, 8'h00, 32'd4000, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_CS, 48'd2200, 16'h1234, -11'sd360, 8'h00, 32'd4000, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_CS, 48'd2300, 16'h0002, 11'h3FF, 8'h01, 32'd4000, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        // stronger packet takes over the lock
        '{'{hdrsc_pkg::REQ_CS, 48'd2400, 16'hABCD, 11'h3FF, 8'h00, 32'd4000, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_RX_END, 48'd2600, 16'h1234, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_RX_END, 48'd2700, 16'hABCD, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_LISTEN, 48'd3000, 16'h0000, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_CS, 48'd3100, 16'h0007, 11'd0, 8'h00, 32'd4000, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        // leaving receive mode spoils the reception in flight
        '{'{hdrsc_pkg::REQ_IDLE, 48'd3200, 16'h0000, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_LISTEN, 48'd3300, 16'h0000, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_CS, 48'd3400, 16'h0008, 11'd100, 8'h00, 32'd4000, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_RX_END, 48'd3500, 16'h0008, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_CS, 48'd3600, 16'h0009, -11'sd100, 8'h00, 32'd4000, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        // error draw drops a clean reception
        '{'{hdrsc_pkg::REQ_RX_END, 48'd3700, 16'h0009, 11'd0, 8'h00, 32'd0, 8'h00, 1'b1,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_TX_START, 48'd4000, 16'h0055, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_TX_END, 48'd4200, 16'h0055, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b0, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_TX_END, 48'd4300, 16'h0055, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd0}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_READ, 48'd4400, 16'h0000, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0,
            1'b1, 3'd7},
          1'b1, '{hdrsc_pkg::ST_IDLE, 1'b0, 1'b0, 1'b0, hdrsc_pkg::LEVEL_NONE, 48'd0}},
        '{'{REQ_UNUSED_TOP, 48'd4500, 16'h5A5A, 11'h2AA, 8'h55, 32'h1234_5678, 8'hAA, 1'b1,
            1'b1, 3'd2},
          1'b1, '{hdrsc_pkg::ST_IDLE, 1'b0, 1'b0, 1'b0, hdrsc_pkg::LEVEL_NONE, 48'd0}},
        '{'{hdrsc_pkg::REQ_READ, 48'hFFFF_FFFF_FFFF, 16'h0000, 11'd0, 8'h00, 32'd0, 8'h00,
            1'b0, 1'b1, 3'd1}, 1'b0, '0},
        '{'{hdrsc_pkg::REQ_SLEEP, 48'hFFFF_FFFF_FFFF, 16'h0000, 11'd0, 8'h00, 32'd0, 8'h00,
            1'b0, 1'b1, 3'd0}, 1'b0, '0},
        // time goes backwards, elapsed time wraps
        '{'{hdrsc_pkg::REQ_READ, 48'd0, 16'h0000, 11'd0, 8'h00, 32'd0, 8'h00, 1'b0, 1'b1,
            3'd0}, 1'b0, '0}
    };

    half_duplex_radio_state_controller_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void clear_radio();
        md = hdrsc_pkg::ST_SLEEP;
        since = '0;
        txv = 0;
        rxv = 0;
        txid = '0;
        rxid = '0;
        lock = hdrsc_pkg::LEVEL_NONE;
        spoil = 0;
        for (int i = 0; i < 5; i++) acc[i] = '0;
        cfg_sens = hdrsc_pkg::SENSITIVITY_RST;
        cfg_chan = '0;
        cfg_sym = hdrsc_pkg::SYMBOL_TIME_RST;
        cfg_mod = '0;
    endfunction

    function automatic void move_to(logic [hdrsc_pkg::STATE_W-1:0] nxt,
                                    logic [hdrsc_pkg::NOW_W-1:0] now);
        if (md == nxt) return;
        if (rxv) spoil = 1;
        acc[md] = acc[md] + (now - since);
        md = nxt;
        since = now;
    endfunction

    function automatic void drop_carrier(logic [hdrsc_pkg::NOW_W-1:0] now);
        txv = 0;
        txid = '0;
        rxv = 0;
        rxid = '0;
        lock = hdrsc_pkg::LEVEL_NONE;
        move_to(hdrsc_pkg::ST_IDLE, now);
    endfunction

    function automatic radio_report_t step_radio(radio_event_t ev);
        radio_report_t rep;
        rep = '0;
        case (ev.req)
            hdrsc_pkg::REQ_TX_START: begin
                if (md == hdrsc_pkg::ST_SLEEP) begin
                    rep.drop = 1'b1;
                end else begin
                    drop_carrier(ev.now);
                    txv = 1;
                    txid = ev.pid;
                    move_to(hdrsc_pkg::ST_TX, ev.now);
                    rep.txs = 1'b1;
                end
            end
            hdrsc_pkg::REQ_TX_END: begin
                if (ev.alive && txv && txid == ev.pid) begin
                    txv = 0;
                    txid = '0;
                    move_to(hdrsc_pkg::ST_IDLE, ev.now);
                end
            end
            hdrsc_pkg::REQ_RX_END: begin
                if (md != hdrsc_pkg::ST_RXING || txv || !rxv || rxid != ev.pid) begin
                    rep.drop = 1'b1;
                end else begin
                    rxv = 0;
                    rxid = '0;
                    lock = hdrsc_pkg::LEVEL_NONE;
                    move_to(hdrsc_pkg::ST_LISTEN, ev.now);
                    if (!ev.alive || ev.per) begin
                        // spoil flag survives this path
                        rep.drop = 1'b1;
                    end else begin
                        if (!spoil) begin
                            move_to(hdrsc_pkg::ST_IDLE, ev.now);
                            rep.fwd = 1'b1;
                        end else begin
                            rep.drop = 1'b1;
                        end
                        spoil = 0;
                    end
                end
            end
            hdrsc_pkg::REQ_CS: begin
                if (!txv && (md == hdrsc_pkg::ST_LISTEN || md == hdrsc_pkg::ST_RXING)
                        && $signed(ev.level) >= cfg_sens && ev.chan == cfg_chan
                        && ev.psym == cfg_sym && ev.pmod == cfg_mod
                        && $signed(ev.level) > lock) begin
                    lock = ev.level;
                    move_to(hdrsc_pkg::ST_RXING, ev.now);
                    rxv = 1;
                    rxid = ev.pid;
                end
            end
            hdrsc_pkg::REQ_SLEEP: begin
                drop_carrier(ev.now);
                move_to(hdrsc_pkg::ST_SLEEP, ev.now);
            end
            hdrsc_pkg::REQ_WAKE: drop_carrier(ev.now);
            hdrsc_pkg::REQ_LISTEN: move_to(hdrsc_pkg::ST_LISTEN, ev.now);
            hdrsc_pkg::REQ_IDLE: move_to(hdrsc_pkg::ST_IDLE, ev.now);
            hdrsc_pkg::REQ_CS_RESET: drop_carrier(ev.now);
            hdrsc_pkg::REQ_READ: begin
                if (ev.sidx < hdrsc_pkg::NUM_STATES) begin
                    rep.dur = acc[ev.sidx];
                    if (ev.sidx == md) rep.dur = rep.dur + (ev.now - since);
                end
            end
            default: ;
        endcase
        rep.state = md;
        rep.lvl = lock;
        return rep;
    endfunction

    function automatic int idle_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [hdrsc_pkg::NOW_W-1:0] advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) clock_ns = clock_ns + 48'($urandom_range(0, 5000));
        else if (r < 93) clock_ns = clock_ns + 48'($urandom());
        else if (r < 98) clock_ns = {16'($urandom()), 32'($urandom())};
        else clock_ns = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 100));
        return clock_ns;
    endfunction

    function automatic radio_event_t fresh(logic [3:0] req);
        radio_event_t ev;
        ev.req = req;
        ev.now = advance_clock();
        ev.pid = 16'($urandom());
        ev.level = 11'($urandom());
        ev.chan = 8'($urandom());
        ev.psym = $urandom();
        ev.pmod = 8'($urandom());
        ev.per = 1'($urandom());
        ev.alive = ($urandom_range(0, 7) != 0);
        ev.sidx = 3'($urandom());
        return ev;
    endfunction

    // carrier sense that matches the current settings, or misses one of them
    function automatic radio_event_t carrier(bit good);
        radio_event_t ev;
        int lo;
        lo = int'(cfg_sens);
        ev = fresh(hdrsc_pkg::REQ_CS);
        ev.chan = cfg_chan;
        ev.psym = cfg_sym;
        ev.pmod = cfg_mod;
        ev.level = 11'($urandom_range(0, 1023 - lo) + lo);
        if (!good) begin
            case ($urandom_range(0, 3))
                0: ev.chan = ev.chan ^ 8'($urandom_range(1, 255));
                1: ev.psym = ev.psym ^ ($urandom() | 32'd1);
                2: ev.pmod = ev.pmod ^ 8'($urandom_range(1, 255));
                default: begin
                    if (lo > -1024) ev.level = 11'(int'($urandom_range(0, lo + 1023)) - 1024);
                    else ev.chan = ev.chan ^ 8'($urandom_range(1, 255));
                end
            endcase
        end
        return ev;
    endfunction

    task automatic send_event(input radio_event_t ev, input bit fixed = 1'b0,
                              input radio_report_t fixed_rep = '0);
        int gap;
        radio_report_t rep;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= ev.req;
        s_tdata <= {ev.sidx, ev.alive, ev.per, ev.pmod, ev.psym, ev.chan, ev.level, ev.pid,
                    ev.now};
        do @(posedge aclk); while (!s_tready);
        rep = step_radio(ev);
        report_q.push_back(fixed ? fixed_rep : rep);
        accepted_events++;
    endtask

    task automatic write_reg(input logic [hdrsc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hdrsc_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            hdrsc_pkg::CFG_SENSITIVITY: cfg_sens = val[hdrsc_pkg::LEVEL_W-1:0];
            hdrsc_pkg::CFG_CHANNEL: cfg_chan = val[hdrsc_pkg::CHAN_W-1:0];
            hdrsc_pkg::CFG_SYMBOL_TIME: cfg_sym = val;
            hdrsc_pkg::CFG_MODULATION: cfg_mod = val[hdrsc_pkg::MOD_W-1:0];
            default: ;
        endcase
    endtask

    // drain every outstanding result, then give the pipeline time to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_episode();
        radio_event_t ev;
        int pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 11) == 0) steady = !steady;
        if (pick < 45) begin
            // listen, offer one to three carrier senses, then end the reception
            if (md == hdrsc_pkg::ST_SLEEP) send_event(fresh(hdrsc_pkg::REQ_WAKE));
            else if (txv) send_event(fresh(hdrsc_pkg::REQ_CS_RESET));
            if (md != hdrsc_pkg::ST_LISTEN && md != hdrsc_pkg::ST_RXING)
                send_event(fresh(hdrsc_pkg::REQ_LISTEN));
            repeat ($urandom_range(1, 3)) begin
                send_event(carrier($urandom_range(0, 4) != 0));
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 5))
                        0: send_event(fresh(hdrsc_pkg::REQ_IDLE));
                        1: send_event(fresh(hdrsc_pkg::REQ_SLEEP));
                        2: send_event(fresh(hdrsc_pkg::REQ_READ));
                        default: send_event(fresh(hdrsc_pkg::REQ_LISTEN));
                    endcase
                end
            end
            ev = fresh(hdrsc_pkg::REQ_RX_END);
            if (rxv && $urandom_range(0, 7) != 0) ev.pid = rxid;
            ev.per = ($urandom_range(0, 6) == 0);
            ev.alive = ($urandom_range(0, 9) != 0);
            send_event(ev);
        end else if (pick < 65) begin
            if (md == hdrsc_pkg::ST_SLEEP && $urandom_range(0, 3) != 0)
                send_event(fresh(hdrsc_pkg::REQ_WAKE));
            send_event(fresh(hdrsc_pkg::REQ_TX_START));
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(0, 1) == 0) send_event(carrier(1'b1));
                else send_event(fresh(hdrsc_pkg::REQ_READ));
            end
            ev = fresh(hdrsc_pkg::REQ_TX_END);
            if (txv && $urandom_range(0, 5) != 0) ev.pid = txid;
            ev.alive = ($urandom_range(0, 9) != 0);
            send_event(ev);
        end else if (pick < 75) begin
            case ($urandom_range(0, 4))
                0: send_event(fresh(hdrsc_pkg::REQ_SLEEP));
                1: send_event(fresh(hdrsc_pkg::REQ_WAKE));
                2: send_event(fresh(hdrsc_pkg::REQ_CS_RESET));
                3: send_event(fresh(hdrsc_pkg::REQ_IDLE));
                default: send_event(fresh(hdrsc_pkg::REQ_LISTEN));
            endcase
        end else if (pick < 88) begin
            ev = fresh(hdrsc_pkg::REQ_READ);
            if ($urandom_range(0, 4) != 0) ev.sidx = 3'($urandom_range(0, 4));
            send_event(ev);
        end else begin
            send_event(fresh(4'($urandom_range(0, 15))));
        end
    endtask

    initial begin
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 2) == 0) stall_left = idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        radio_report_t got;
        radio_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.state = m_tdata[2:0];
            got.txs = m_tdata[3];
            got.fwd = m_tdata[4];
            got.drop = m_tdata[5];
            got.lvl = m_tdata[16:6];
            got.dur = m_tdata[64:17];
            if (report_q.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                mismatches++;
            end else begin
                want = report_q.pop_front();
                if (got.state !== want.state) begin
                    $error("radio_state expected %0d got %0d", want.state, got.state);
                    mismatches++;
                end
                if (got.txs !== want.txs) begin
                    $error("transmit_start expected %0d got %0d", want.txs, got.txs);
                    mismatches++;
                end
                if (got.fwd !== want.fwd) begin
                    $error("forward_packet expected %0d got %0d", want.fwd, got.fwd);
                    mismatches++;
                end
                if (got.drop !== want.drop) begin
                    $error("dropped expected %0d got %0d", want.drop, got.drop);
                    mismatches++;
                end
                if (got.lvl !== want.lvl) begin
                    $error("cs_level expected %0d got %0d", $signed(want.lvl), $signed(got.lvl));
                    mismatches++;
                end
                if (got.dur !== want.dur) begin
                    $error("duration_value expected %0d got %0d", want.dur, got.dur);
                    mismatches++;
                end
            end
        end
    end

    // far beyond the slowest legal run, including every long stall on both sides
    initial begin
        #5000000;
        $display("half_duplex_radio_state_controller_top test failed");
        $finish;
    end

    initial begin
        int goal;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        steady = 0;
        accepted_events = 0;
        mismatches = 0;
        clock_ns = '0;
        clear_radio();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) send_event(script[i].ev, script[i].fixed, script[i].rep);
        clock_ns = '0;

        for (int ph = 0; ph < 5; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(hdrsc_pkg::CFG_SENSITIVITY,
                              {21'($urandom()), hdrsc_pkg::LEVEL_NONE});
                    write_reg(hdrsc_pkg::CFG_CHANNEL, {24'($urandom()), 8'hFF});
                    write_reg(hdrsc_pkg::CFG_SYMBOL_TIME, 32'hFFFF_FFFF);
                    write_reg(hdrsc_pkg::CFG_MODULATION, {24'($urandom()), 8'hFF});
                end
                1: begin
                    write_reg(hdrsc_pkg::CFG_SENSITIVITY, {21'($urandom()), 11'h3FF});
                    write_reg(hdrsc_pkg::CFG_CHANNEL, {24'($urandom()), 8'h00});
                    write_reg(hdrsc_pkg::CFG_SYMBOL_TIME, 32'd0);
                    write_reg(hdrsc_pkg::CFG_MODULATION, {24'($urandom()), 8'h00});
                end
                2: begin
                    write_reg(hdrsc_pkg::CFG_SENSITIVITY,
                              {21'($urandom()), hdrsc_pkg::SENSITIVITY_RST});
                    write_reg(hdrsc_pkg::CFG_CHANNEL, 32'd0);
                    write_reg(hdrsc_pkg::CFG_SYMBOL_TIME, hdrsc_pkg::SYMBOL_TIME_RST);
                    write_reg(hdrsc_pkg::CFG_MODULATION, 32'd0);
                end
                default: begin
                    write_reg(hdrsc_pkg::CFG_SENSITIVITY, $urandom());
                    write_reg(hdrsc_pkg::CFG_CHANNEL, $urandom());
                    write_reg(hdrsc_pkg::CFG_SYMBOL_TIME, $urandom());
                    write_reg(hdrsc_pkg::CFG_MODULATION, $urandom());
                end
            endcase
            goal = accepted_events + PHASE_EVENTS;
            while (accepted_events < goal) random_episode();
        end
        settle();

        if (mismatches == 0) begin
            $display("half_duplex_radio_state_controller_top test passed");
        end else begin
            $display("half_duplex_radio_state_controller_top test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hdrsc_pkg.sv
rtl/core/hdrsc_front.sv
rtl/core/hdrsc_queue.sv
rtl/core/hdrsc_back.sv
rtl/core/half_duplex_radio_state_controller_top.sv
test/tb_half_duplex_radio_state_controller_top.sv
